FILE: hw/rtl/polyphase_fir_decimator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polyphase decimator
// Implication checks on the clock; they compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_FIR_DECIMATOR_TOP_ASSERT_SVH
`define POLYPHASE_FIR_DECIMATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define PFD_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PFD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFD_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons, msg)
`define PFD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, codes and default sizes of the polyphase decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  localparam int MAX_TAPS_DEF       = 256;
  localparam int MAX_DECIMATION_DEF = 16;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int COEF_BITS_DEF      = 16;

  // Configuration register widths and reset values.
  localparam int DEC_W       = 5;
  localparam int TAPS_W      = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int COEF_IDX_W  = 8;

  localparam logic [DEC_W-1:0]  DEC_RESET  = DEC_W'(1);
  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(256);

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT  = 1'b1;

  // Input commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic shift;   // take the left neighbor (new sample enters)
    logic rotate;  // take the right neighbor (ring rotation)
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;    // zero the accumulator
    logic issue;    // a tap is presented this cycle
    logic use_tap;  // the presented tap is inside the tap count
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pfd_cell.sv
// ----------------------------------------------------------------------------
// pfd_cell
// One delay-line cell: shifts from the left or rotates from the right.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_cell #(
  parameter int SAMPLE_BITS = pfd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire pfd_pkg::cell_ctrl_t      ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic signed [SAMPLE_BITS-1:0] q
);

  logic signed [SAMPLE_BITS-1:0] q_r;
  logic signed [SAMPLE_BITS-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift) begin
      q_nxt = left_in;
    end else if (ctrl.rotate) begin
      q_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pfd_coef_mem.sv
// ----------------------------------------------------------------------------
// pfd_coef_mem
// Coefficient table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_coef_mem #(
  parameter int DEPTH     = pfd_pkg::MAX_TAPS_DEF,
  parameter int ADDR_BITS = 8,
  parameter int COEF_BITS = pfd_pkg::COEF_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire logic [ADDR_BITS-1:0]    wr_addr,
  input  wire logic signed [COEF_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0]    rd_addr,
  output logic signed [COEF_BITS-1:0]  rd_data
);

  logic signed [COEF_BITS-1:0] mem [DEPTH];
  logic signed [COEF_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pfd_mac.sv
// ----------------------------------------------------------------------------
// pfd_mac
// Shared multiply-accumulate with round-half-up and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_mac #(
  parameter int SAMPLE_BITS = pfd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = pfd_pkg::COEF_BITS_DEF,
  parameter int ACC_BITS    = 41
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire pfd_pkg::mac_ctrl_t           ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] tap_sample,
  input  wire logic signed [COEF_BITS-1:0]   tap_coef,
  output logic                              busy,
  output logic signed [SAMPLE_BITS-1:0]     result,
  output logic                              saturated
);

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam logic signed [ACC_BITS-1:0] RND    = ACC_BITS'(1 << (COEF_BITS - 2));
  localparam logic signed [ACC_BITS-1:0] LIM_HI = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] LIM_LO = ~LIM_HI;

  logic                          v1_r, use1_r, v2_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic signed [PROD_BITS-1:0]   prod_w;
  logic signed [ACC_BITS-1:0]    prod_r;
  logic signed [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic signed [ACC_BITS-1:0]    rnd_sum, rnd_shift;

  // Sample is registered here so it lines up with the registered memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
    end
  end

  assign prod_w = smp_r * tap_coef;

  always_ff @(posedge clk) begin
    smp_r  <= tap_sample;
    use1_r <= ctrl.use_tap;
    prod_r <= use1_r ? ACC_BITS'(prod_w) : '0;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign rnd_sum   = acc_r + RND;
  assign rnd_shift = rnd_sum >>> (COEF_BITS - 1);

  always_comb begin
    if (rnd_shift > LIM_HI) begin
      result    = LIM_HI[SAMPLE_BITS-1:0];
      saturated = 1'b1;
    end else if (rnd_shift < LIM_LO) begin
      result    = LIM_LO[SAMPLE_BITS-1:0];
      saturated = 1'b1;
    end else begin
      result    = rnd_shift[SAMPLE_BITS-1:0];
      saturated = 1'b0;
    end
  end

  assign busy = v1_r | v2_r;

endmodule

`default_nettype wire

FILE: hw/rtl/polyphase_fir_decimator_top.sv
// ----------------------------------------------------------------------------
// polyphase_fir_decimator_top
// Decimating FIR filter built around a ring of delay-line cells and one MAC.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   command, sample, coef index/value
//   out_      output     out_valid / out_ready sample_out, saturated
//   cfg_      input      cfg_wr_en             cfg_index, cfg_wr_data
//
// A coefficient write or a sample that produces no output leaves the block idle.
// A sample that produces an output holds in_ready low while the delay-line
// ring rotates once through all MAX_TAPS cells, one tap per cycle into the
// shared multiplier, and while the MAC pipeline drains.
// Reset is synchronous and active low; it clears the delay line, the phase
// count and the registers. The coefficient table is not cleared.
// A stalled output only holds the block when a new result is ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_fir_decimator_top #(
  parameter int MAX_TAPS       = pfd_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIMATION = pfd_pkg::MAX_DECIMATION_DEF,
  parameter int SAMPLE_BITS    = pfd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS      = pfd_pkg::COEF_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  // Configuration write port.
  input  wire                                      cfg_wr_en,
  input  wire logic [pfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  // Input channel.
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire                                      in_command,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  input  wire logic [pfd_pkg::COEF_IDX_W-1:0]      in_coef_index,
  input  wire logic signed [COEF_BITS-1:0]         in_coef_value,
  // Result channel.
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [SAMPLE_BITS-1:0]            out_sample_out,
  output logic                                     out_saturated
);

`include "polyphase_fir_decimator_top_assert.svh"

  localparam int KW       = $clog2(MAX_TAPS);
  localparam int PW       = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int MCW      = $clog2(MAX_DECIMATION + 1);
  localparam int MW       = (pfd_pkg::DEC_W > MCW) ? pfd_pkg::DEC_W : MCW;
  localparam int CTW      = (pfd_pkg::TAPS_W > KW) ? pfd_pkg::TAPS_W : KW;
  localparam int IW       = (pfd_pkg::COEF_IDX_W > KW) ? pfd_pkg::COEF_IDX_W : KW;
  localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + KW + 1;
  localparam logic [KW-1:0] K_LAST = KW'(MAX_TAPS - 1);

  // Config registers. The user writes only while the block is idle; unchecked.
  logic [pfd_pkg::DEC_W-1:0]  dec_r;
  logic [pfd_pkg::TAPS_W-1:0] taps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r  <= pfd_pkg::DEC_RESET;
      taps_r <= pfd_pkg::TAPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pfd_pkg::REG_DECIMATION: dec_r  <= cfg_wr_data[pfd_pkg::DEC_W-1:0];
        pfd_pkg::REG_TAP_COUNT:  taps_r <= cfg_wr_data[pfd_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective decimation factor: zero acts as one, large values clip.
  logic [MW-1:0] dec_ext, m_eff;

  assign dec_ext = MW'(dec_r);

  always_comb begin
    if (dec_ext == '0) begin
      m_eff = MW'(1);
    end else if (dec_ext > MAX_DECIMATION) begin
      m_eff = MW'(MAX_DECIMATION);
    end else begin
      m_eff = dec_ext;
    end
  end

  // Sequencer state.
  pfd_pkg::state_t state_r, state_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [PW-1:0]   phase_r, phase_nxt;
  logic [MW-1:0]   phase_inc;
  logic            out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic            out_sat_r;
  logic            out_load;

  logic                in_xfer;
  logic                is_sample, is_coef, emit;
  pfd_pkg::cell_ctrl_t cell_ctrl;
  pfd_pkg::mac_ctrl_t  mac_ctrl;
  logic                mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_result;
  logic                mac_sat;

  assign in_xfer   = in_valid && in_ready;
  assign is_sample = (in_command == pfd_pkg::CMD_SAMPLE);
  assign is_coef   = (in_command == pfd_pkg::CMD_COEF);
  assign emit      = (phase_r == '0);
  assign phase_inc = MW'(phase_r) + MW'(1);

  always_comb begin
    state_nxt        = state_r;
    k_nxt            = k_r;
    phase_nxt        = phase_r;
    in_ready         = 1'b0;
    out_load         = 1'b0;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.issue   = 1'b0;
    mac_ctrl.use_tap = (CTW'(k_r) < CTW'(taps_r));

    case (state_r)
      pfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer && is_sample) begin
          // The new sample enters the ring; the phase count moves on and
          // wraps once it reaches the decimation factor.
          cell_ctrl.shift = 1'b1;
          phase_nxt = (phase_inc >= m_eff) ? '0 : phase_inc[PW-1:0];
          if (emit) begin
            mac_ctrl.clear = 1'b1;
            k_nxt          = '0;
            state_nxt      = pfd_pkg::ST_CALC;
          end
        end
      end
      pfd_pkg::ST_CALC: begin
        // Cell zero holds x[n-k] in this cycle, the table is read at k.
        mac_ctrl.issue   = 1'b1;
        cell_ctrl.rotate = 1'b1;
        k_nxt            = k_r + KW'(1);
        if (k_r == K_LAST) begin
          state_nxt = pfd_pkg::ST_DRAIN;
        end
      end
      pfd_pkg::ST_DRAIN: begin
        // Wait for the last product to land, then hand the result over as
        // soon as the output register is free.
        if (!mac_busy && (!out_valid_r || out_ready)) begin
          out_load  = 1'b1;
          state_nxt = pfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfd_pkg::ST_IDLE;
      k_r         <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= mac_result;
      out_sat_r    <= mac_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // Delay line: a ring of cells. Cell i holds x[n-i] between computations.
  // A new sample shifts in at cell zero; during a computation the ring
  // rotates toward cell zero and is back in place after MAX_TAPS steps.
  logic signed [SAMPLE_BITS-1:0] tap_w [MAX_TAPS];

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_sample_in;
    end else begin : g_mid
      assign left_w = tap_w[i-1];
    end
    if (i == MAX_TAPS - 1) begin : g_last
      assign right_w = tap_w[0];
    end else begin : g_inner
      assign right_w = tap_w[i+1];
    end
    pfd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .left_in  (left_w),
      .right_in (right_w),
      .q        (tap_w[i])
    );
  end

  // Coefficient table. Writes beyond MAX_TAPS are dropped.
  logic [IW-1:0] coef_idx_ext;
  logic          coef_wr;
  logic signed [COEF_BITS-1:0] coef_rd;

  assign coef_idx_ext = IW'(in_coef_index);
  assign coef_wr      = in_xfer && is_coef && (coef_idx_ext < MAX_TAPS);

  pfd_coef_mem #(
    .DEPTH     (MAX_TAPS),
    .ADDR_BITS (KW),
    .COEF_BITS (COEF_BITS)
  ) u_coef_mem (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (coef_idx_ext[KW-1:0]),
    .wr_data (in_coef_value),
    .rd_addr (k_r),
    .rd_data (coef_rd)
  );

  pfd_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (mac_ctrl),
    .tap_sample (tap_w[0]),
    .tap_coef   (coef_rd),
    .busy       (mac_busy),
    .result     (mac_result),
    .saturated  (mac_sat)
  );

  // Checks on the sequencer.
  `PFD_ASSERT_IMPL(a_ready_mac_idle, clk, rst_n, in_ready, !mac_busy, "ready while MAC busy")
  `PFD_ASSERT_NEXT(a_calc_full_turn, clk, rst_n, (state_r == pfd_pkg::ST_CALC) && (k_r != K_LAST), state_r == pfd_pkg::ST_CALC, "ring left before a full turn")
  `PFD_ASSERT_NEXT(a_coef_stays_idle, clk, rst_n, in_xfer && is_coef, state_r == pfd_pkg::ST_IDLE, "coefficient write started work")
  `PFD_ASSERT_IMPL(a_load_when_free, clk, rst_n, out_load, !out_valid_r || out_ready, "result overwrote a pending output")

endmodule

`default_nettype wire
